### hdl/ccd_pkg.sv
// Package for the clock/calendar display block: state and result types,
// configuration indexes and the seven-segment table. No dependencies.
package ccd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTE     = 2'd2;

    localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd244;
    localparam logic [4:0]  ALARM_HOUR_RST       = 5'd7;
    localparam logic [5:0]  ALARM_MINUTE_RST     = 6'd0;

    // Display mode codes; every other code shows hour:minute.
    localparam logic [2:0] MODE_YEAR    = 3'd5;
    localparam logic [2:0] MODE_DATE    = 3'd6;
    localparam logic [2:0] MODE_MIN_SEC = 3'd3;

    typedef struct packed {
        logic [15:0] ticks_per_second;
        logic [4:0]  alarm_hour;
        logic [5:0]  alarm_minute;
    } ccd_cfg_t;

    // Year digits: index 0 is thousands, index 3 is units.
    typedef struct packed {
        logic [3:0][3:0] year;
        logic [3:0]      month;
        logic [4:0]      day;
        logic [1:0]      hr_t;
        logic [3:0]      hr_u;
        logic [2:0]      min_t;
        logic [3:0]      min_u;
        logic [2:0]      sec_t;
        logic [3:0]      sec_u;
    } ccd_time_t;

    localparam ccd_time_t TIME_RST = '{
        year:  {4'd8, 4'd1, 4'd0, 4'd2},
        month: 4'd2,
        day:   5'd28,
        hr_t:  2'd2,
        hr_u:  4'd3,
        min_t: 3'd5,
        min_u: 4'd9,
        sec_t: 3'd5,
        sec_u: 4'd5
    };

    // Packed so that segments sit in the lowest bits.
    typedef struct packed {
        logic       second_tick;
        logic       alarm;
        logic [1:0] digit_select;
        logic [7:0] segments;
    } ccd_result_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'hFC;
            4'd1:    pat = 8'h60;
            4'd2:    pat = 8'hDA;
            4'd3:    pat = 8'hF2;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'hB6;
            4'd6:    pat = 8'hBE;
            4'd7:    pat = 8'hE4;
            4'd8:    pat = 8'hFE;
            4'd9:    pat = 8'hF6;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

### hdl/ccd_time.sv
// BCD time and calendar counter cascade, scan position and alarm compare.
// Depends on ccd_pkg.
module ccd_time
    import ccd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  ccd_cfg_t   cfg,
    output ccd_time_t  time_cur,
    output logic [1:0] pos_next,
    output logic       alarm_next,
    output logic       tick_next
);

    logic [1:0]  scan_reg, scan_next;
    logic [15:0] subtick_reg, subtick_next;
    ccd_time_t   time_reg, time_next;

    logic [15:0] cnt_inc;
    logic        bump;
    logic        c_st, c_mu, c_mt, c_h, c_d, c_m;
    logic        c_y;
    logic [4:0]  mlen;
    logic        leap;
    logic [1:0]  low_mod4;
    logic [1:0]  high_mod4;
    logic        low_zero;
    logic [4:0]  hour_val;
    logic [5:0]  min_val;

    assign scan_next = advance ? scan_reg + 2'd1 : scan_reg;
    assign pos_next  = scan_reg + 2'd1;
    assign bump      = advance && !pos_next[0];
    assign cnt_inc   = subtick_reg + 16'd1;
    assign tick_next = bump && (cnt_inc >= cfg.ticks_per_second);

    always_comb begin
        subtick_next = subtick_reg;
        if (tick_next) begin
            subtick_next = '0;
        end else if (bump) begin
            subtick_next = cnt_inc;
        end
    end

    // Leap year from BCD digits: low two digits mod 4 is 2*tens + units mod 4.
    assign low_mod4  = time_reg.year[3][1:0] + {time_reg.year[2][0], 1'b0};
    assign high_mod4 = time_reg.year[1][1:0] + {time_reg.year[0][0], 1'b0};
    assign low_zero  = (time_reg.year[3] == 4'd0) && (time_reg.year[2] == 4'd0);
    assign leap      = low_zero ? (high_mod4 == 2'd0) : (low_mod4 == 2'd0);

    always_comb begin
        case (time_reg.month)
            4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
            4'd2:                    mlen = leap ? 5'd29 : 5'd28;
            default:                 mlen = 5'd31;
        endcase
    end

    always_comb begin
        time_next = time_reg;
        c_st = 1'b0;
        c_mu = 1'b0;
        c_mt = 1'b0;
        c_h  = 1'b0;
        c_d  = 1'b0;
        c_m  = 1'b0;
        c_y  = 1'b0;
        if (tick_next) begin
            if (time_reg.sec_u == 4'd9) begin
                time_next.sec_u = '0;
                c_st = 1'b1;
            end else begin
                time_next.sec_u = time_reg.sec_u + 4'd1;
            end
        end
        if (c_st) begin
            if (time_reg.sec_t == 3'd5) begin
                time_next.sec_t = '0;
                c_mu = 1'b1;
            end else begin
                time_next.sec_t = time_reg.sec_t + 3'd1;
            end
        end
        if (c_mu) begin
            if (time_reg.min_u == 4'd9) begin
                time_next.min_u = '0;
                c_mt = 1'b1;
            end else begin
                time_next.min_u = time_reg.min_u + 4'd1;
            end
        end
        if (c_mt) begin
            if (time_reg.min_t == 3'd5) begin
                time_next.min_t = '0;
                c_h = 1'b1;
            end else begin
                time_next.min_t = time_reg.min_t + 3'd1;
            end
        end
        if (c_h) begin
            if (time_reg.hr_t == 2'd2 && time_reg.hr_u == 4'd3) begin
                time_next.hr_t = '0;
                time_next.hr_u = '0;
                c_d = 1'b1;
            end else if (time_reg.hr_u == 4'd9) begin
                time_next.hr_u = '0;
                time_next.hr_t = time_reg.hr_t + 2'd1;
            end else begin
                time_next.hr_u = time_reg.hr_u + 4'd1;
            end
        end
        if (c_d) begin
            if (time_reg.day >= mlen) begin
                time_next.day = 5'd1;
                c_m = 1'b1;
            end else begin
                time_next.day = time_reg.day + 5'd1;
            end
        end
        if (c_m) begin
            if (time_reg.month >= 4'd12) begin
                time_next.month = 4'd1;
                c_y = 1'b1;
            end else begin
                time_next.month = time_reg.month + 4'd1;
            end
        end
        // Year ripples from units (index 3) up to thousands; 9999 wraps to 0.
        for (int i = 3; i >= 0; i--) begin
            if (c_y) begin
                if (time_reg.year[i] == 4'd9) begin
                    time_next.year[i] = '0;
                end else begin
                    time_next.year[i] = time_reg.year[i] + 4'd1;
                    c_y = 1'b0;
                end
            end
        end
    end

    assign hour_val   = {time_next.hr_t, 3'b000} + {2'b00, time_next.hr_t, 1'b0}
                      + {1'b0, time_next.hr_u};
    assign min_val    = {time_next.min_t, 3'b000} + {2'b00, time_next.min_t, 1'b0}
                      + {2'b00, time_next.min_u};
    assign alarm_next = (hour_val == cfg.alarm_hour) && (min_val == cfg.alarm_minute);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg    <= '0;
            subtick_reg <= '0;
            time_reg    <= TIME_RST;
        end else if (advance) begin
            scan_reg    <= scan_next;
            subtick_reg <= subtick_next;
            time_reg    <= time_next;
        end
    end

    assign time_cur = time_reg;

endmodule

### hdl/ccd_display.sv
// Digit selection for the chosen view and seven-segment lookup.
// Depends on ccd_pkg.
module ccd_display
    import ccd_pkg::*;
(
    input  ccd_time_t  time_cur,
    input  logic [2:0] mode,
    input  logic [1:0] pos,
    output logic [7:0] segments
);

    logic [1:0] day_t;
    logic [4:0] day_rem;
    logic       mon_t;
    logic [3:0] mon_u;
    logic [3:0] digit;

    always_comb begin
        if (time_cur.day >= 5'd30) begin
            day_t   = 2'd3;
            day_rem = time_cur.day - 5'd30;
        end else if (time_cur.day >= 5'd20) begin
            day_t   = 2'd2;
            day_rem = time_cur.day - 5'd20;
        end else if (time_cur.day >= 5'd10) begin
            day_t   = 2'd1;
            day_rem = time_cur.day - 5'd10;
        end else begin
            day_t   = 2'd0;
            day_rem = time_cur.day;
        end
        mon_t = time_cur.month >= 4'd10;
        mon_u = mon_t ? time_cur.month - 4'd10 : time_cur.month;
    end

    always_comb begin
        case (mode)
            MODE_YEAR: begin
                case (pos)
                    2'd3:    digit = time_cur.year[2];
                    2'd2:    digit = time_cur.year[3];
                    2'd1:    digit = time_cur.year[1];
                    default: digit = time_cur.year[0];
                endcase
            end
            MODE_DATE: begin
                case (pos)
                    2'd3:    digit = {2'b00, day_t};
                    2'd2:    digit = day_rem[3:0];
                    2'd1:    digit = mon_u;
                    default: digit = {3'b000, mon_t};
                endcase
            end
            MODE_MIN_SEC: begin
                case (pos)
                    2'd3:    digit = {1'b0, time_cur.sec_t};
                    2'd2:    digit = time_cur.sec_u;
                    2'd1:    digit = time_cur.min_u;
                    default: digit = {1'b0, time_cur.min_t};
                endcase
            end
            default: begin
                case (pos)
                    2'd3:    digit = {1'b0, time_cur.min_t};
                    2'd2:    digit = time_cur.min_u;
                    2'd1:    digit = time_cur.hr_u;
                    default: digit = {2'b00, time_cur.hr_t};
                endcase
            end
        endcase
    end

    assign segments = seg_pattern(digit);

endmodule

### hdl/ccd_outbuf.sv
// Result register with a skid stage, so input acceptance continues while
// a result waits. Depends on ccd_pkg.
module ccd_outbuf
    import ccd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  ccd_result_t in_data,
    output logic        in_ready,
    output logic        out_valid,
    output ccd_result_t out_data,
    input  logic        out_ready
);

    logic        out_valid_reg;
    ccd_result_t out_data_reg;
    logic        skid_valid_reg;
    ccd_result_t skid_data_reg;
    logic        take;

    assign in_ready  = !skid_valid_reg;
    assign take      = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            if (skid_valid_reg) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else if (in_valid) begin
                out_data_reg <= in_data;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg) begin
                out_data_reg  <= in_data;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

### hdl/clock_calendar_display.sv
// Top level of the BCD clock/calendar with multiplexed seven-segment output.
// Depends on ccd_pkg, ccd_time, ccd_display and ccd_outbuf.
//
//   channel   direction  tdata fields (lowest bit up)                 handshake
//   s_        in         display_mode[2:0], zero pad to 8 bits        s_tvalid/s_tready
//   m_        out        segments[7:0], digit_select[9:8], alarm[10], m_tvalid/m_tready
//                        second_tick[11], zero pad to 16 bits
//   cfg_wr_   in         cfg_wr_index selects register, cfg_wr_data   cfg_wr_en
//
// One item per clock while s_tready is high: an accepted tick updates the counter
// cascade and the scan position in that cycle, and its result is registered.
// Synchronous active-low reset loads the calendar start values and the
// register defaults. A stalled output holds one result in the output
// register and one in the skid stage; s_tready drops only when both are full.
module clock_calendar_display
    import ccd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,      // display_mode[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,      // segments, digit_select, alarm, second_tick
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    ccd_cfg_t    cfg_reg;
    ccd_time_t   time_cur;
    logic        accept;
    logic [1:0]  pos_next;
    logic        alarm_next;
    logic        tick_next;
    logic [7:0]  segments;
    ccd_result_t result;
    ccd_result_t out_data;

    assign accept = s_tvalid && s_tready;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_second <= TICKS_PER_SECOND_RST;
            cfg_reg.alarm_hour       <= ALARM_HOUR_RST;
            cfg_reg.alarm_minute     <= ALARM_MINUTE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= cfg_wr_data;
                CFG_ALARM_HOUR:       cfg_reg.alarm_hour       <= cfg_wr_data[4:0];
                CFG_ALARM_MINUTE:     cfg_reg.alarm_minute     <= cfg_wr_data[5:0];
                default: ;
            endcase
        end
    end

    // Advance scan position, subticks and calendar on every accepted item.
    ccd_time u_time (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (accept),
        .cfg        (cfg_reg),
        .time_cur   (time_cur),
        .pos_next   (pos_next),
        .alarm_next (alarm_next),
        .tick_next  (tick_next)
    );

    // The shown digit comes from the time before this tick's update.
    ccd_display u_display (
        .time_cur (time_cur),
        .mode     (s_tdata[2:0]),
        .pos      (pos_next),
        .segments (segments)
    );

    always_comb begin
        result.segments     = segments;
        result.digit_select = pos_next;
        result.alarm        = alarm_next;
        result.second_tick  = tick_next;
    end

    // Hold results until the downstream side takes them.
    ccd_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_data   (result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign m_tdata = {4'b0000, out_data};

endmodule

### verif/clock_calendar_display_tb.sv
// Self-checking testbench for clock_calendar_display: drives refresh ticks and
// register writes, predicts every display item and compares it on the m_ side.
// Depends on ccd_pkg and the RTL under hdl/.
module clock_calendar_display_tb;
    import ccd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int TAIL_TICKS   = 200;   // closing stretch with no idling
    localparam int PHASE_TICKS  = 200;   // ticks in each random phase

    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Segment glyphs for BCD digits; codes above 9 blank the digit.
    localparam logic [7:0] GLYPH [16] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE4,
        8'hFE, 8'hF6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata      = '0;
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    // Predicted state of the clock, its registers and the scan counter.
    ccd_cfg_t    clk_cfg;
    ccd_time_t   clk_now;
    logic [1:0]  scan_pos;
    logic [15:0] subticks;

    // Display items predicted but not yet seen on the m_ side, oldest first.
    ccd_result_t pending_display [$];

    // Traffic controls shared by the test tasks and the receiver.
    bit idle_on     = 1'b0;
    int hold_cycles = 0;
    int rx_gap      = 0;

    int cycle_count    = 0;
    int ticks_sent     = 0;
    int items_checked  = 0;
    int seconds_seen   = 0;
    int alarms_seen    = 0;
    int mismatch_count = 0;

    ccd_result_t seen_item;
    ccd_result_t want_item;

    clock_calendar_display dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),        // display_mode[2:0], zero pad
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),        // segments, digit_select, alarm, second_tick, pad
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Clock and calendar prediction
    // ---------------------------------------------------------------
    function automatic int days_in_month();
        int yr;
        yr = clk_now.year[0] * 1000 + clk_now.year[1] * 100 +
             clk_now.year[2] * 10 + clk_now.year[3];
        case (clk_now.month)
            4, 6, 9, 11: return 30;
            2: begin
                // Gregorian rule; the wrapped year 0 counts as divisible by 400.
                if (((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0)
                    return 29;
                return 28;
            end
            default: return 31;
        endcase
    endfunction

    function automatic void bump_year();
        for (int i = 3; i >= 0; i--) begin
            clk_now.year[i] = clk_now.year[i] + 4'd1;
            if (clk_now.year[i] < 4'd10)
                return;
            clk_now.year[i] = 4'd0;
        end
    endfunction

    // Ripple one second through the BCD cascade and the calendar.
    function automatic void advance_clock();
        clk_now.sec_u = clk_now.sec_u + 4'd1;
        if (clk_now.sec_u < 4'd10) return;
        clk_now.sec_u = '0;
        clk_now.sec_t = clk_now.sec_t + 3'd1;
        if (clk_now.sec_t < 3'd6) return;
        clk_now.sec_t = '0;
        clk_now.min_u = clk_now.min_u + 4'd1;
        if (clk_now.min_u < 4'd10) return;
        clk_now.min_u = '0;
        clk_now.min_t = clk_now.min_t + 3'd1;
        if (clk_now.min_t < 3'd6) return;
        clk_now.min_t = '0;
        clk_now.hr_u = clk_now.hr_u + 4'd1;
        if (clk_now.hr_u == 4'd10) begin
            clk_now.hr_u = '0;
            clk_now.hr_t = clk_now.hr_t + 2'd1;
        end
        if (clk_now.hr_t == 2'd2 && clk_now.hr_u == 4'd4) begin
            clk_now.hr_t = '0;
            clk_now.hr_u = '0;
            // Compare in int so day 31 plus one does not wrap the field.
            if (int'(clk_now.day) + 1 > days_in_month()) begin
                clk_now.day = 5'd1;
                clk_now.month = clk_now.month + 4'd1;
                if (clk_now.month > 4'd12) begin
                    clk_now.month = 4'd1;
                    bump_year();
                end
            end else begin
                clk_now.day = clk_now.day + 5'd1;
            end
        end
    endfunction

    function automatic int hours_now();
        return clk_now.hr_t * 10 + clk_now.hr_u;
    endfunction

    function automatic int minutes_now();
        return clk_now.min_t * 10 + clk_now.min_u;
    endfunction

    // Advance the scan, pick the digit of the chosen view, bump the subtick
    // count on even positions and build the display item this tick causes.
    function automatic ccd_result_t next_display(input logic [2:0] mode);
        ccd_result_t r;
        logic [3:0]  digit;
        logic        ticked;
        ticked   = 1'b0;
        scan_pos = scan_pos + 2'd1;
        case (mode)
            MODE_YEAR: begin
                case (scan_pos)
                    2'd3:    digit = clk_now.year[2];
                    2'd2:    digit = clk_now.year[3];
                    2'd1:    digit = clk_now.year[1];
                    default: digit = clk_now.year[0];
                endcase
            end
            MODE_DATE: begin
                case (scan_pos)
                    2'd3:    digit = 4'(clk_now.day / 10);
                    2'd2:    digit = 4'(clk_now.day % 10);
                    2'd1:    digit = 4'(clk_now.month % 10);
                    default: digit = 4'(clk_now.month / 10);
                endcase
            end
            MODE_MIN_SEC: begin
                case (scan_pos)
                    2'd3:    digit = 4'(clk_now.sec_t);
                    2'd2:    digit = clk_now.sec_u;
                    2'd1:    digit = clk_now.min_u;
                    default: digit = 4'(clk_now.min_t);
                endcase
            end
            default: begin
                case (scan_pos)
                    2'd3:    digit = 4'(clk_now.min_t);
                    2'd2:    digit = clk_now.min_u;
                    2'd1:    digit = clk_now.hr_u;
                    default: digit = 4'(clk_now.hr_t);
                endcase
            end
        endcase
        if (!scan_pos[0]) begin
            subticks = subticks + 16'd1;
            // Compare after the bump, so a lowered threshold fires at once.
            if (subticks >= clk_cfg.ticks_per_second) begin
                subticks = '0;
                advance_clock();
                ticked = 1'b1;
            end
        end
        r.segments     = GLYPH[digit];
        r.digit_select = scan_pos;
        r.alarm        = (hours_now() == clk_cfg.alarm_hour) &&
                         (minutes_now() == clk_cfg.alarm_minute);
        r.second_tick  = ticked;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Driving tasks; each starts and ends at a falling edge
    // ---------------------------------------------------------------

    // Offer one tick and hold it until accepted. tvalid stays high on return,
    // so a back-to-back tick never lowers and raises it in one time step.
    task automatic send_tick(input logic [2:0] mode);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, mode};
        do @(posedge aclk); while (!s_tready);
        pending_display.push_back(next_display(mode));
        ticks_sent++;
        @(negedge aclk);
    endtask

    // Drop tvalid and wait until every predicted item has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_display.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_TICKS_PER_SECOND: clk_cfg.ticks_per_second = data;
            CFG_ALARM_HOUR:       clk_cfg.alarm_hour       = data[4:0];
            CFG_ALARM_MINUTE:     clk_cfg.alarm_minute     = data[5:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when asked for
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 19) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Checker: compare each accepted item with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            items_checked++;
            seen_item = m_tdata[11:0];
            if (seen_item.second_tick === 1'b1) seconds_seen++;
            if (seen_item.alarm === 1'b1)       alarms_seen++;
            if (pending_display.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] display item %h with nothing predicted", $realtime, m_tdata);
            end else begin
                want_item = pending_display.pop_front();
                if (seen_item.segments !== want_item.segments ||
                    seen_item.digit_select !== want_item.digit_select ||
                    seen_item.alarm !== want_item.alarm ||
                    seen_item.second_tick !== want_item.second_tick ||
                    m_tdata[15:12] !== 4'b0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display(
                            "[%0t] item %0d exp/got: seg %h/%h digit %0d/%0d alarm %b/%b sec %b/%b pad %h",
                            $realtime, items_checked,
                            want_item.segments, seen_item.segments,
                            want_item.digit_select, seen_item.digit_select,
                            want_item.alarm, seen_item.alarm,
                            want_item.second_tick, seen_item.second_tick,
                            m_tdata[15:12]);
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Show every view at the reset registers; no second is reached yet.
    task automatic test_display_modes();
        for (int m = 0; m < 8; m++)
            send_tick(3'(m));
        wait_idle();
    endtask

    // Lower the threshold under the running subtick count: next bump fires.
    task automatic test_lowered_threshold();
        write_reg(CFG_TICKS_PER_SECOND, 16'd2);
        send_tick(MODE_MIN_SEC);
        send_tick(MODE_MIN_SEC);
        wait_idle();
    endtask

    // Zero threshold: every bump is a second. Cross midnight at 00:00 alarm,
    // rolling the last day of February into March.
    task automatic test_midnight_rollover();
        write_reg(CFG_ALARM_HOUR, 16'd0);
        write_reg(CFG_ALARM_MINUTE, 16'd0);
        write_reg(CFG_TICKS_PER_SECOND, 16'd0);
        send_tick(MODE_MIN_SEC);
        send_tick(MODE_MIN_SEC);
        send_tick(3'd0);
        send_tick(3'd7);
        send_tick(MODE_DATE);
        send_tick(MODE_DATE);
        send_tick(MODE_DATE);
        send_tick(MODE_DATE);
        send_tick(MODE_YEAR);
        send_tick(MODE_YEAR);
        wait_idle();
    endtask

    // Alarm registers outside the clock's range never match.
    task automatic test_unreachable_alarm();
        write_reg(CFG_ALARM_HOUR, 16'd31);
        write_reg(CFG_ALARM_MINUTE, 16'd63);
        send_tick(3'd0);
        send_tick(3'd4);
        wait_idle();
        write_reg(CFG_ALARM_HOUR, 16'd23);
        write_reg(CFG_ALARM_MINUTE, 16'd59);
        write_reg(CFG_TICKS_PER_SECOND, 16'hFFFF);
        send_tick(3'd1);
        wait_idle();
    endtask

    // Writes to the spare index must leave all registers alone.
    task automatic test_unknown_index();
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_UNUSED, 16'h0000);
        send_tick(3'd2);
        send_tick(MODE_MIN_SEC);
        wait_idle();
    endtask

    // Hold the receiver off while the sender keeps offering ticks, so the
    // output stages fill and s_tready drops.
    task automatic test_backpressure();
        write_reg(CFG_TICKS_PER_SECOND, 16'd1);
        hold_cycles = 300;
        for (int n = 0; n < 48; n++)
            send_tick(3'($urandom_range(0, 7)));
        wait_idle();
    endtask

    // Random views under changing registers, with idling on both sides.
    task automatic test_random();
        logic [15:0] tps;
        int          pick;
        idle_on = 1'b1;
        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0:       tps = 16'd0;
                1:       tps = 16'd1;
                2:       tps = 16'($urandom_range(2, 12));
                3:       tps = 16'hFFFF;
                4:       tps = 16'($urandom_range(0, 65535));
                default: tps = 16'($urandom_range(1, 4));
            endcase
            write_reg(CFG_TICKS_PER_SECOND, tps);
            // Aim the alarm at the current or next minute most of the time.
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
                write_reg(CFG_ALARM_HOUR, 16'(hours_now()));
                write_reg(CFG_ALARM_MINUTE, 16'(minutes_now()));
            end else if (pick == 1) begin
                write_reg(CFG_ALARM_HOUR, 16'($urandom_range(0, 31)));
                write_reg(CFG_ALARM_MINUTE, 16'($urandom_range(0, 63)));
            end else begin
                write_reg(CFG_ALARM_HOUR, 16'(hours_now()));
                write_reg(CFG_ALARM_MINUTE, 16'((minutes_now() + 1) % 60));
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
            for (int n = 0; n < PHASE_TICKS; n++)
                send_tick(3'($urandom_range(0, 7)));
        end
        wait_idle();
    endtask

    // Close with a stretch at full rate and no idling on either side, one
    // second per two ticks.
    task automatic test_full_day();
        idle_on = 1'b0;
        write_reg(CFG_TICKS_PER_SECOND, 16'd0);
        write_reg(CFG_ALARM_HOUR, 16'($urandom_range(0, 23)));
        write_reg(CFG_ALARM_MINUTE, 16'($urandom_range(0, 59)));
        for (int n = 0; n < TAIL_TICKS; n++)
            send_tick(3'($urandom_range(0, 7)));
        wait_idle();
    endtask

    initial begin
        // Reset values of the registers and of the calendar.
        clk_cfg.ticks_per_second = 16'd244;
        clk_cfg.alarm_hour       = 5'd7;
        clk_cfg.alarm_minute     = 6'd0;
        clk_now.year  = {4'd8, 4'd1, 4'd0, 4'd2};
        clk_now.month = 4'd2;
        clk_now.day   = 5'd28;
        clk_now.hr_t  = 2'd2;
        clk_now.hr_u  = 4'd3;
        clk_now.min_t = 3'd5;
        clk_now.min_u = 4'd9;
        clk_now.sec_t = 3'd5;
        clk_now.sec_u = 4'd5;
        scan_pos = 2'd0;
        subticks = 16'd0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_display_modes();
        test_lowered_threshold();
        test_midnight_rollover();
        test_unreachable_alarm();
        test_unknown_index();
        test_backpressure();
        test_random();
        test_full_day();

        repeat (8) @(negedge aclk);
        $display("Checked %0d display items from %0d ticks over all eight views,",
                 items_checked, ticks_sent);
        $display("%0d second advances, %0d with alarm high, calendar at %0d%0d%0d%0d-%0d-%0d.",
                 seconds_seen, alarms_seen, clk_now.year[0], clk_now.year[1],
                 clk_now.year[2], clk_now.year[3], clk_now.month, clk_now.day);
        if (mismatch_count == 0 && pending_display.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d items still predicted",
                     mismatch_count, pending_display.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/ccd_pkg.sv
hdl/ccd_time.sv
hdl/ccd_display.sv
hdl/ccd_outbuf.sv
hdl/clock_calendar_display.sv
verif/clock_calendar_display_tb.sv
